// ===== rtl/alcv_pkg.sv =====
// ----------------------------------------------------------------------------
// alcv_pkg
// Shared constants and controller/datapath interface types for the
// line-to-channel converter.
// ----------------------------------------------------------------------------
package alcv_pkg;

	// Line store geometry.
	localparam int LINE_DEPTH = 64;
	localparam int POS_W      = $clog2(LINE_DEPTH);
	localparam logic [POS_W-1:0] LAST_POS = POS_W'(LINE_DEPTH - 1);
	localparam logic [POS_W-1:0] PREFIX_LEN = POS_W'(3);

	// Character codes.
	localparam logic [7:0] CH_T     = 8'h54;
	localparam logic [7:0] CH_X     = 8'h58;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TILDE = 8'h7E;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic store;      // append the input character to the line
		logic clear_pos;  // return the line position to zero
		logic start;      // set up a walk over the line body
		logic read;       // read the line store at the walk index
		logic digit;      // fold the read digit into the accumulator
		logic emit;       // send a channel write, not last
		logic emit_last;  // send the final channel write of the line
	} alcv_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic printable;  // input character is printable
		logic term;       // input is a terminator on a non-empty line
		logic parse_ok;   // line is long enough and carries the prefix
		logic walk_done;  // walk index has reached the line position
		logic rd_digit;   // character read from the store is a digit
		logic out_free;   // output register can take a new transfer
	} alcv_sts_t;

endpackage

// ===== rtl/ascii_line_to_channel_values_top.sv =====
// ----------------------------------------------------------------------------
// ascii_line_to_channel_values_top
// Collects printable characters into a line and turns a "TX:" line into a
// series of channel writes, one transfer per parsed decimal value.
// ----------------------------------------------------------------------------
// A printable or ignored character is accepted without stalling the input.
// A terminated "TX:" line stalls the input while its body is walked: each body
// character is read from the line store, then accumulated or emitted, and the
// final write follows; the single read port forces the read before each step.
// Throughput: one character per cycle between terminators; input is stalled
// during a walk. Reset clears the line position, walk state and output valid.
module ascii_line_to_channel_values_top import alcv_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_char,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [5:0] channel,
	output logic [7:0] level,
	output logic       last_write
);

	alcv_cmd_t cmd;
	alcv_sts_t sts;

	// Sequencer.
	alcv_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Line store, parser and output register.
	alcv_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.rx_char    (rx_char),
		.cmd        (cmd),
		.sts        (sts),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.channel    (channel),
		.level      (level),
		.last_write (last_write)
	);

endmodule

// ===== rtl/alcv_dp.sv =====
// ----------------------------------------------------------------------------
// alcv_dp
// Datapath: line store memory, line position, prefix flags, walk index,
// decimal accumulator, channel counter and the output register.
// ----------------------------------------------------------------------------
module alcv_dp import alcv_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [7:0]       rx_char,
	input  alcv_cmd_t        cmd,
	output alcv_sts_t        sts,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [5:0]       channel,
	output logic [7:0]       level,
	output logic             last_write
);

	logic [7:0]       mem [LINE_DEPTH];
	logic [7:0]       rd_data_q;
	logic [POS_W-1:0] pos_q;
	logic [POS_W-1:0] k_q;
	logic [2:0]       prefix_q;
	logic [7:0]       acc_q;
	logic [5:0]       chan_q;
	logic             out_valid_q;
	logic [5:0]       channel_q;
	logic [7:0]       level_q;
	logic             last_q;
	logic [7:0]       acc_next;

	// Line store: written on append, read at the walk index.
	always_ff @(posedge clk) begin
		if (cmd.store) begin
			mem[pos_q] <= rx_char;
		end
		if (cmd.read) begin
			rd_data_q <= mem[k_q];
		end
	end

	// Line position and prefix flags for the first three entries.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			prefix_q <= '0;
		end else begin
			if (cmd.store) begin
				pos_q <= (pos_q == LAST_POS) ? '0 : pos_q + POS_W'(1);
				if (pos_q == POS_W'(0)) begin
					prefix_q[0] <= (rx_char == CH_T);
				end
				if (pos_q == POS_W'(1)) begin
					prefix_q[1] <= (rx_char == CH_X);
				end
				if (pos_q == POS_W'(2)) begin
					prefix_q[2] <= (rx_char == CH_COLON);
				end
			end else if (cmd.clear_pos) begin
				pos_q <= '0;
			end
		end
	end

	// Accumulator times ten plus the new digit, modulo 256.
	assign acc_next = {acc_q[4:0], 3'b000} + {acc_q[6:0], 1'b0} + (rd_data_q - CH_ZERO);

	// Walk index, accumulator and channel counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q    <= '0;
			acc_q  <= '0;
			chan_q <= 6'd1;
		end else begin
			if (cmd.start) begin
				k_q    <= PREFIX_LEN;
				acc_q  <= '0;
				chan_q <= 6'd1;
			end else if (cmd.digit) begin
				k_q   <= k_q + POS_W'(1);
				acc_q <= acc_next;
			end else if (cmd.emit) begin
				k_q    <= k_q + POS_W'(1);
				acc_q  <= '0;
				chan_q <= chan_q + 6'd1;
			end
		end
	end

	// Output register: holds one transfer until the receiver takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit || cmd.emit_last) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit || cmd.emit_last) begin
			channel_q <= chan_q;
			level_q   <= acc_q;
			last_q    <= cmd.emit_last;
		end
	end

	// Status decode.
	always_comb begin
		sts.printable = (rx_char >= CH_SPACE) && (rx_char <= CH_TILDE);
		sts.term      = ((rx_char == CH_LF) || (rx_char == CH_CR)) && (pos_q != '0);
		sts.parse_ok  = (pos_q >= PREFIX_LEN) && (&prefix_q);
		sts.walk_done = (k_q == pos_q);
		sts.rd_digit  = (rd_data_q >= CH_ZERO) && (rd_data_q <= CH_NINE);
		sts.out_free  = !out_valid_q || !out_stall;
	end

	assign out_valid  = out_valid_q;
	assign channel    = channel_q;
	assign level      = level_q;
	assign last_write = last_q;

	// A new transfer is never loaded over one that is still waiting.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit || cmd.emit_last) |-> !(out_valid_q && out_stall))
		else $error("output register overwritten while stalled");

	// The walk never reads beyond the characters of the current line.
	a_read_in_line: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.read |-> (k_q < pos_q))
		else $error("line store read beyond the line position");

	// The line position does not move while a line is being walked.
	a_pos_held: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.read || cmd.digit || cmd.emit) |=> $stable(pos_q))
		else $error("line position changed during a walk");

endmodule

// ===== rtl/alcv_ctrl.sv =====
// ----------------------------------------------------------------------------
// alcv_ctrl
// Controller: accepts characters and, on a prefixed line, sequences the
// walk over the stored body and the channel writes.
// ----------------------------------------------------------------------------
module alcv_ctrl import alcv_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  alcv_sts_t sts,
	output alcv_cmd_t cmd
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_RD   = 4'b0010,
		ST_PROC = 4'b0100,
		ST_FIN  = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;

	// Next state and command decode.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (sts.printable) begin
						cmd.store = 1'b1;
					end else if (sts.term) begin
						if (sts.parse_ok) begin
							cmd.start = 1'b1;
							state_d   = ST_RD;
						end else begin
							cmd.clear_pos = 1'b1;
						end
					end
				end
			end
			ST_RD: begin
				if (sts.walk_done) begin
					state_d = ST_FIN;
				end else begin
					cmd.read = 1'b1;
					state_d  = ST_PROC;
				end
			end
			ST_PROC: begin
				if (sts.rd_digit) begin
					cmd.digit = 1'b1;
					state_d   = ST_RD;
				end else if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_RD;
				end
			end
			ST_FIN: begin
				if (sts.out_free) begin
					cmd.emit_last = 1'b1;
					cmd.clear_pos = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall = (state_q != ST_IDLE);

	// A walk starts only on a terminated line that carries the prefix.
	a_start_ok: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |-> (in_valid && sts.term && sts.parse_ok))
		else $error("walk started on a line without the prefix");

	// The final write of a line returns the controller to idle.
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_last |=> (state_q == ST_IDLE))
		else $error("controller not idle after the final write");

	// A read is followed in the next cycle by ST_PROC, which consumes the character as digit or separator.
	a_read_used: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.read |=> (state_q == ST_PROC))
		else $error("read data not processed");

endmodule
